// ===== sv/cor_pkg.sv =====
// Shared types and constants for the circle outline rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package cor_pkg;

    localparam int COORD_BITS_DEF = 8;

    localparam int COL_W   = 8;
    localparam int ROW_W   = 8;
    localparam int RAD_W   = 7;
    localparam int CLR_W   = 16;
    localparam int PIX_W   = 16;
    localparam int NUM_PIX = 8;

    localparam int SX_W = 13;
    localparam int SY_W = 12;
    localparam int SR_W = 13;

    localparam int IN_W  = 40;
    localparam int OUT_W = NUM_PIX * PIX_W + CLR_W;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take a new circle command
        logic step;   // emit current pixels into the output word and advance
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic at_limit;   // current y is the final one of this circle
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/cor_ctrl.sv =====
// Controller for the circle outline rasterizer: command sequencing and output handshake.
`timescale 1ns / 1ps
`default_nettype none

module cor_ctrl
    import cor_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_valid,
    output logic       o_s_ready,
    output logic       o_m_valid,
    input  wire logic  i_m_ready,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_load, w_slot_free, w_step;

    assign o_s_ready   = (r_state == ST_IDLE);
    assign w_load      = i_s_valid && o_s_ready;
    // output word is free when empty or being taken this cycle
    assign w_slot_free = !r_out_valid || i_m_ready;
    assign w_step      = (r_state == ST_RUN) && w_slot_free;

    assign o_cmd.load = w_load;
    assign o_cmd.step = w_step;
    assign o_m_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_step && i_stat.at_limit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load) |=> (r_state == ST_RUN))
        else $error("accepted command did not start a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && i_stat.at_limit) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("final word did not end the run with a valid output");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_out_valid && !i_m_ready) |=>
            (r_state == ST_RUN && r_out_valid))
        else $error("run advanced while the output word was stalled");

endmodule

`default_nettype wire

// ===== sv/cor_dp.sv =====
// Datapath for the circle outline rasterizer: triangular-sum iteration and pixel mirroring.
`timescale 1ns / 1ps
`default_nettype none

module cor_dp
    import cor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [COL_W-1:0]  i_center_col,
    input  wire logic [ROW_W-1:0]  i_center_row,
    input  wire logic [RAD_W-1:0]  i_radius,
    input  wire logic [CLR_W-1:0]  i_color,
    output logic [OUT_W-1:0]       o_data,   // 8 pixels, then color
    output logic                   o_last
);

    localparam int CB = COORD_BITS;

    // command registers
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [RAD_W-1:0] r_rad;
    logic [CLR_W-1:0] r_color;

    // iteration state
    logic [RAD_W-1:0] r_x, r_y;
    logic [SX_W-1:0]  r_sx;
    logic [SY_W-1:0]  r_sy;
    logic [SR_W-1:0]  r_sr;

    // output word
    logic [OUT_W-1:0] r_data;
    logic             r_last;

    logic [RAD_W:0]    w_rad_p1;
    logic [14:0]       w_prod;
    logic [SR_W-1:0]   w_sr_new;
    logic [RAD_W-1:0]  w_y1;
    logic [SY_W-1:0]   w_sy1;
    logic [SY_W+1:0]   w_tot;
    logic              w_dec;
    logic              w_at_limit;

    logic [CB-1:0] w_c, w_r, w_x, w_y;
    logic [CB-1:0] w_cpx, w_cnx, w_cpy, w_cny;
    logic [CB-1:0] w_rpx, w_rnx, w_rpy, w_rny;
    logic [OUT_W-1:0] w_data;

    function automatic logic [PIX_W-1:0] pack_pix(input logic [CB-1:0] c,
                                                  input logic [CB-1:0] r);
        logic [2*CB-1:0] w;
        w = {r, c};
        return w[PIX_W-1:0];
    endfunction

    // r(r+1)/2 on the incoming radius
    assign w_rad_p1 = {1'b0, i_radius} + (RAD_W+1)'(1);
    assign w_prod   = 15'(i_radius) * 15'(w_rad_p1);
    assign w_sr_new = w_prod[SR_W:1];

    assign w_y1       = r_y + RAD_W'(1);
    assign w_sy1      = r_sy + SY_W'(w_y1);
    assign w_tot      = (SY_W+2)'(r_sx) + (SY_W+2)'(w_sy1);
    assign w_dec      = w_tot > (SY_W+2)'(r_sr);
    assign w_at_limit = (r_y == {1'b0, r_rad[RAD_W-1:1]});

    assign o_stat.at_limit = w_at_limit;

    // coordinates wrap modulo 2^COORD_BITS
    assign w_c   = CB'(r_col);
    assign w_r   = CB'(r_row);
    assign w_x   = CB'(r_x);
    assign w_y   = CB'(r_y);
    assign w_cpx = w_c + w_x;
    assign w_cnx = w_c - w_x;
    assign w_cpy = w_c + w_y;
    assign w_cny = w_c - w_y;
    assign w_rpx = w_r + w_x;
    assign w_rnx = w_r - w_x;
    assign w_rpy = w_r + w_y;
    assign w_rny = w_r - w_y;

    assign w_data = {r_color,
                     pack_pix(w_cny, w_rnx),
                     pack_pix(w_cny, w_rpx),
                     pack_pix(w_cpy, w_rnx),
                     pack_pix(w_cpy, w_rpx),
                     pack_pix(w_cnx, w_rny),
                     pack_pix(w_cnx, w_rpy),
                     pack_pix(w_cpx, w_rny),
                     pack_pix(w_cpx, w_rpy)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col   <= i_center_col;
            r_row   <= i_center_row;
            r_rad   <= i_radius;
            r_color <= i_color;
            r_x     <= i_radius;
            r_y     <= '0;
            r_sx    <= w_sr_new;
            r_sy    <= '0;
            r_sr    <= w_sr_new;
        end else if (i_cmd.step) begin
            r_y  <= w_y1;
            r_sy <= w_sy1;
            if (w_dec) begin
                r_sx <= r_sx - SX_W'(r_x);
                r_x  <= r_x - RAD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_data <= w_data;
            r_last <= w_at_limit;
        end
    end

    assign o_data = r_data;
    assign o_last = r_last;

endmodule

`default_nettype wire

// ===== sv/circle_outline_rasterizer_top.sv =====
// Top level of the circle outline rasterizer: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Draws one circle per input word as eight-way mirrored pixel sets. A command
// of radius r yields floor(r/2)+1 output words (at most 64), the last one
// marked with tlast. Once the command is taken, the iteration register set
// in the datapath advances one y step per cycle while the output side does
// not stall, and each step fills the output register. A new command is
// taken once the final word of the previous circle has been loaded into the
// output register. Pixels wrap modulo 2^COORD_BITS and are not clipped;
// each pixel packs the column in the low COORD_BITS bits and the row above
// it, cut to 16 bits.
module circle_outline_rasterizer_top
    import cor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // center_col[7:0], center_row[15:8], radius[22:16], color[38:23], zero pad
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // pix_pxpy, pix_pxny, pix_nxpy, pix_nxny, pix_pypx, pix_pynx, pix_nypx,
    // pix_nynx, pixel_color; 16 bits each from bit 0 up
    output logic [OUT_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tlast   // last_of_run
);

    t_cmd  w_cmd;
    t_stat w_stat;

    cor_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd),
        .i_stat    (w_stat)
    );

    cor_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_center_col (s_axis_tdata[7:0]),
        .i_center_row (s_axis_tdata[15:8]),
        .i_radius     (s_axis_tdata[22:16]),
        .i_color      (s_axis_tdata[38:23]),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire
